// File: design/gift64_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and round functions for the GIFT-64 cipher pipeline.
// Used by gift64_round_cell and gift64_block_cipher; depends on nothing else.
package gift64_pkg;

  // Number of rounds and the round constant table.
  localparam int ROUND_COUNT_DEFAULT = 28;
  localparam int RC_COUNT = 28;

  localparam logic [7:0] ROUND_CONST [RC_COUNT] = '{
    8'h01, 8'h03, 8'h07, 8'h0F, 8'h1F, 8'h3E, 8'h3D, 8'h3B,
    8'h37, 8'h2F, 8'h1E, 8'h3C, 8'h39, 8'h33, 8'h27, 8'h0E,
    8'h1D, 8'h3A, 8'h35, 8'h2B, 8'h16, 8'h2C, 8'h18, 8'h30,
    8'h21, 8'h02, 8'h05, 8'h0B
  };

  // Fixed bit that goes into slice 3 with every round constant.
  localparam logic [15:0] SLICE3_MARK = 16'h8000;

  // Direction codes.
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 2'd1;

  // Four 16-bit slices of the cipher state; element q is slice q.
  typedef logic [3:0][15:0] slices_t;

  // One beat travelling down the chain of round cells.
  typedef struct packed {
    logic    decrypt;
    logic [7:0] tweak;
    slices_t state;
  } beat_t;

  // Rotate a 16-bit word left by n bits.
  function automatic logic [15:0] rotl16(input logic [15:0] x, input logic [3:0] n);
    logic [31:0] t;
    t = {x, x} << n;
    return t[31:16];
  endfunction

  // Spread a 64-bit block into slices: bit i goes to slice i mod 4, position i / 4.
  function automatic slices_t block_to_slices(input logic [63:0] blk);
    slices_t s;
    for (int i = 0; i < 64; i++) begin
      s[i % 4][i / 4] = blk[i];
    end
    return s;
  endfunction

  // Gather slices back into a 64-bit block.
  function automatic logic [63:0] slices_to_block(input slices_t s);
    logic [63:0] blk;
    for (int i = 0; i < 64; i++) begin
      blk[i] = s[i % 4][i / 4];
    end
    return blk;
  endfunction

  // Per-slice bit permutation: bit j moves to j/4 + 4*((3*(j mod 4) + s) mod 4).
  function automatic logic [15:0] perm_fwd(input logic [15:0] x, input int sl);
    logic [15:0] y;
    for (int j = 0; j < 16; j++) begin
      y[(j / 4) + 4 * (((3 * (j % 4)) + sl) % 4)] = x[j];
    end
    return y;
  endfunction

  function automatic logic [15:0] perm_inv(input logic [15:0] x, input int sl);
    logic [15:0] y;
    for (int j = 0; j < 16; j++) begin
      y[j] = x[(j / 4) + 4 * (((3 * (j % 4)) + sl) % 4)];
    end
    return y;
  endfunction

  // Bit-sliced S-box, forward direction.
  function automatic slices_t sbox_fwd(input slices_t s);
    logic [15:0] s0, s1, s2, s3;
    slices_t r;
    s0 = s[0];
    s1 = s[1];
    s2 = s[2];
    s3 = s[3];
    s1 = s1 ^ (s0 & s2);
    s0 = s0 ^ (s1 & s3);
    s2 = s2 ^ (s0 | s1);
    s3 = s3 ^ s2;
    s1 = s1 ^ s3;
    s3 = ~s3;
    s2 = s2 ^ (s0 & s1);
    r[0] = s3;
    r[1] = s1;
    r[2] = s2;
    r[3] = s0;
    return r;
  endfunction

  // Bit-sliced S-box, inverse direction.
  function automatic slices_t sbox_inv(input slices_t s);
    logic [15:0] s0, s1, s2, s3;
    slices_t r;
    s0 = s[3];
    s1 = s[1];
    s2 = s[2];
    s3 = s[0];
    s2 = s2 ^ (s0 & s1);
    s3 = ~s3;
    s1 = s1 ^ s3;
    s3 = s3 ^ s2;
    s2 = s2 ^ (s0 | s1);
    s0 = s0 ^ (s1 & s3);
    s1 = s1 ^ (s0 & s2);
    r[0] = s0;
    r[1] = s1;
    r[2] = s2;
    r[3] = s3;
    return r;
  endfunction

endpackage

// File: design/gift64_round_cell.sv
`timescale 1ns / 1ps
// One cell of the round chain: holds one beat and applies one encryption round
// or one decryption round to it. Depends on gift64_pkg.
module gift64_round_cell import gift64_pkg::*; #(
  parameter int ROUND_COUNT = ROUND_COUNT_DEFAULT,
  parameter int CELL_IDX    = 0
) (
  input  logic         clk,
  input  logic         rst,
  input  logic [63:0]  key_low,
  input  logic [63:0]  key_high,
  input  logic         up_valid,
  output logic         up_ready,
  input  beat_t        up_beat,
  output logic         dn_valid,
  input  logic         dn_ready,
  output beat_t        dn_beat
);

  // Encryption walks the rounds forwards along the chain, decryption backwards.
  localparam int ENC_R = CELL_IDX;
  localparam int DEC_R = ROUND_COUNT - 1 - CELL_IDX;

  // Key pair used by each round and how far its words have been rotated.
  localparam int ENC_PAIR = ENC_R % 4;
  localparam int DEC_PAIR = DEC_R % 4;
  localparam logic [3:0] ENC_ROT_A = 4'((4 * (ENC_R / 4)) % 16);
  localparam logic [3:0] ENC_ROT_B = 4'((14 * (ENC_R / 4)) % 16);
  localparam logic [3:0] DEC_ROT_A = 4'((4 * (DEC_R / 4)) % 16);
  localparam logic [3:0] DEC_ROT_B = 4'((14 * (DEC_R / 4)) % 16);

  // Round constants and tweak placement (every fourth round but the last).
  localparam logic [15:0] ENC_CONST = SLICE3_MARK ^ {8'h00, ROUND_CONST[ENC_R % RC_COUNT]};
  localparam logic [15:0] DEC_CONST = SLICE3_MARK ^ {8'h00, ROUND_CONST[DEC_R % RC_COUNT]};
  localparam bit ENC_TWEAK = (((ENC_R + 1) % 4) == 0) && (ENC_R < ROUND_COUNT - 1);
  localparam bit DEC_TWEAK = (((DEC_R + 1) % 4) == 0) && (DEC_R < ROUND_COUNT - 1);

  logic [127:0] key_full;
  logic [31:0]  enc_pair_words;
  logic [31:0]  dec_pair_words;
  logic [15:0]  enc_ka, enc_kb, dec_ka, dec_kb;
  logic [15:0]  tweak_word;
  slices_t      enc_state, dec_state;
  slices_t      enc_mid, dec_mid;
  logic         take;
  logic         valid;
  beat_t        beat;

  // Round keys are fixed rotations of the held key words.
  assign key_full       = {key_high, key_low};
  assign enc_pair_words = key_full[32*ENC_PAIR +: 32];
  assign dec_pair_words = key_full[32*DEC_PAIR +: 32];
  assign enc_ka         = rotl16(enc_pair_words[15:0], ENC_ROT_A);
  assign enc_kb         = rotl16(enc_pair_words[31:16], ENC_ROT_B);
  assign dec_ka         = rotl16(dec_pair_words[15:0], DEC_ROT_A);
  assign dec_kb         = rotl16(dec_pair_words[31:16], DEC_ROT_B);
  assign tweak_word     = {up_beat.tweak, up_beat.tweak};

  // Forward round: S-box, permutation, key and constant, then the tweak.
  always_comb begin
    enc_mid = sbox_fwd(up_beat.state);
    for (int q = 0; q < 4; q++) begin
      enc_state[q] = perm_fwd(enc_mid[q], q);
    end
    enc_state[0] = enc_state[0] ^ enc_ka;
    enc_state[1] = enc_state[1] ^ enc_kb;
    enc_state[3] = enc_state[3] ^ ENC_CONST;
    if (ENC_TWEAK) begin
      enc_state[2] = enc_state[2] ^ tweak_word;
    end
  end

  // Inverse round: undo constant, tweak and key, then permutation and S-box.
  always_comb begin
    dec_mid    = up_beat.state;
    dec_mid[3] = dec_mid[3] ^ DEC_CONST;
    if (DEC_TWEAK) begin
      dec_mid[2] = dec_mid[2] ^ tweak_word;
    end
    dec_mid[0] = dec_mid[0] ^ dec_ka;
    dec_mid[1] = dec_mid[1] ^ dec_kb;
    for (int q = 0; q < 4; q++) begin
      dec_mid[q] = perm_inv(dec_mid[q], q);
    end
    dec_state = sbox_inv(dec_mid);
  end

  // The cell takes a new beat when it is empty or its own beat moves on.
  assign take     = !valid || dn_ready;
  assign up_ready = take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && up_valid) begin
      beat.decrypt <= up_beat.decrypt;
      beat.tweak   <= up_beat.tweak;
      beat.state   <= (up_beat.decrypt == OP_DECRYPT) ? dec_state : enc_state;
    end
  end

  assign dn_valid = valid;
  assign dn_beat  = beat;

endmodule

// File: design/gift64_block_cipher.sv
`timescale 1ns / 1ps
// Top level of the GIFT-64 cipher: key registers, block slicing and the chain
// of round cells. Depends on gift64_pkg and gift64_round_cell.

// The block accepts one 64-bit block every clock cycle unless a stall at the
// output has backed up to the input, in either direction and with any tweak
// byte. Each result passes through the chain of round cells, one cell per
// round, each holding one beat in flight, and leaves from the last cell. A
// stall at the output backs up only as far as the nearest empty cell, so input
// beats keep being taken while bubbles remain in the chain. The 128-bit key
// sits in two 64-bit registers that clear to zero on reset; write them only
// while no block is in flight.
module gift64_block_cipher import gift64_pkg::*; #(
  parameter int ROUND_COUNT = ROUND_COUNT_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]            cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   opcode,
  input  logic [63:0]            block_in,
  input  logic [7:0]             tweak_byte,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [63:0]            block_out
);

  logic [63:0] key_low_half;
  logic [63:0] key_high_half;

  logic  link_valid [ROUND_COUNT+1];
  logic  link_ready [ROUND_COUNT+1];
  beat_t link_beat  [ROUND_COUNT+1];

  // Key registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low_half  <= '0;
      key_high_half <= '0;
    end else if (cfg_write_en) begin
      if (cfg_index == REG_KEY_LOW) begin
        key_low_half <= cfg_data;
      end else if (cfg_index == REG_KEY_HIGH) begin
        key_high_half <= cfg_data;
      end
    end
  end

  // Input beat enters the chain in sliced form.
  assign link_valid[0]         = in_valid;
  assign in_ready              = link_ready[0];
  assign link_beat[0].decrypt  = opcode;
  assign link_beat[0].tweak    = tweak_byte;
  assign link_beat[0].state    = block_to_slices(block_in);

  // Chain of round cells.
  for (genvar c = 0; c < ROUND_COUNT; c++) begin : g_cell
    gift64_round_cell #(
      .ROUND_COUNT (ROUND_COUNT),
      .CELL_IDX    (c)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .key_low  (key_low_half),
      .key_high (key_high_half),
      .up_valid (link_valid[c]),
      .up_ready (link_ready[c]),
      .up_beat  (link_beat[c]),
      .dn_valid (link_valid[c+1]),
      .dn_ready (link_ready[c+1]),
      .dn_beat  (link_beat[c+1])
    );
  end

  // The last cell is the output register.
  assign out_valid                = link_valid[ROUND_COUNT];
  assign link_ready[ROUND_COUNT]  = out_ready;
  assign block_out                = slices_to_block(link_beat[ROUND_COUNT].state);

  // Reset empties the chain, so no result beat is shown after it.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat shown straight after reset");

  // A free output side must let the whole chain move.
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input blocked although the output is taking beats");

  // The input can only be blocked by a stalled result.
  a_block_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input blocked without a stalled result");

endmodule

// File: tb/sv/gift64_block_cipher_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for gift64_block_cipher: encrypts and decrypts blocks
// under several keys and tweaks and checks every result beat against a predictor.
// Depends on gift64_pkg and the design files of gift64_block_cipher.
module gift64_block_cipher_test import gift64_pkg::*;;

  localparam int NUM_ROUNDS = 28;
  localparam int LATENCY_PAD = NUM_ROUNDS + 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;
  localparam logic [15:0] LANE3_MARK = 16'h8000;
  // Register indexes that the block does not implement.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam logic [7:0] RC_TABLE [NUM_ROUNDS] = '{
    8'h01, 8'h03, 8'h07, 8'h0F, 8'h1F, 8'h3E, 8'h3D, 8'h3B,
    8'h37, 8'h2F, 8'h1E, 8'h3C, 8'h39, 8'h33, 8'h27, 8'h0E,
    8'h1D, 8'h3A, 8'h35, 8'h2B, 8'h16, 8'h2C, 8'h18, 8'h30,
    8'h21, 8'h02, 8'h05, 8'h0B
  };

  typedef logic [3:0][15:0] lanes_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [63:0]            cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic                   opcode;
  logic [63:0]            block_in;
  logic [7:0]             tweak_byte;
  logic                   out_valid;
  logic                   out_ready;
  logic [63:0]            block_out;

  // Predictor copy of the key registers and the queue of blocks still owed.
  logic [63:0] key_low_model;
  logic [63:0] key_high_model;
  logic [63:0] pending_blocks [$];
  logic [63:0] owed_block;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  bit          steady;

  gift64_block_cipher DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .block_in     (block_in),
    .tweak_byte   (tweak_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .block_out    (block_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Rotation of a 16-bit key word; n is between 1 and 15.
  function automatic logic [15:0] rot_left16(input logic [15:0] x, input int n);
    return (x << n) | (x >> (16 - n));
  endfunction

  // Bit shuffle within one lane; the undo flag selects the inverse mapping.
  function automatic logic [15:0] lane_shuffle(input logic [15:0] x, input int lane,
                                               input bit undo);
    logic [15:0] y;
    int d;
    y = '0;
    for (int j = 0; j < 16; j++) begin
      d = (j / 4) + 4 * (((3 * (j % 4)) + lane) % 4);
      if (undo) begin
        y[j] = x[d];
      end else begin
        y[d] = x[j];
      end
    end
    return y;
  endfunction

  // Sliced S-box, forward: the last step swaps lanes 0 and 3.
  function automatic lanes_t sbox_layer(input lanes_t s);
    logic [15:0] w0, w1, w2, w3;
    w0 = s[0];
    w1 = s[1];
    w2 = s[2];
    w3 = s[3];
    w1 ^= w0 & w2;
    w0 ^= w1 & w3;
    w2 ^= w0 | w1;
    w3 ^= w2;
    w1 ^= w3;
    w3 = ~w3;
    w2 ^= w0 & w1;
    return {w0, w2, w1, w3};
  endfunction

  // Sliced S-box, inverse: undoes the steps above in reverse order.
  function automatic lanes_t sbox_layer_inv(input lanes_t s);
    logic [15:0] w0, w1, w2, w3;
    w0 = s[3];
    w1 = s[1];
    w2 = s[2];
    w3 = s[0];
    w2 ^= w0 & w1;
    w3 = ~w3;
    w1 ^= w3;
    w3 ^= w2;
    w2 ^= w0 | w1;
    w0 ^= w1 & w3;
    w1 ^= w0 & w2;
    return {w3, w2, w1, w0};
  endfunction

  // Full tweaked cipher in either direction under the current model key.
  function automatic logic [63:0] gift_transform(input logic op, input logic [63:0] blk,
                                                 input logic [7:0] tw);
    logic [15:0] ka [4];
    logic [15:0] kb [4];
    logic [15:0] rka [NUM_ROUNDS];
    logic [15:0] rkb [NUM_ROUNDS];
    lanes_t      s;
    logic [15:0] tw2;
    logic [63:0] res;
    int          p;
    ka[3] = key_low_model[15:0];
    kb[3] = key_low_model[31:16];
    ka[2] = key_low_model[47:32];
    kb[2] = key_low_model[63:48];
    ka[1] = key_high_model[15:0];
    kb[1] = key_high_model[31:16];
    ka[0] = key_high_model[47:32];
    kb[0] = key_high_model[63:48];
    // Key schedule: each pair is used every fourth round, rotating after use.
    for (int r = 0; r < NUM_ROUNDS; r++) begin
      p = 3 - (r % 4);
      rka[r] = ka[p];
      rkb[r] = kb[p];
      ka[p] = rot_left16(ka[p], 4);
      kb[p] = rot_left16(kb[p], 14);
    end
    for (int i = 0; i < 64; i++) begin
      s[i % 4][i / 4] = blk[i];
    end
    tw2 = {tw, tw};
    if (op == OP_ENCRYPT) begin
      for (int r = 0; r < NUM_ROUNDS; r++) begin
        s = sbox_layer(s);
        for (int q = 0; q < 4; q++) begin
          s[q] = lane_shuffle(s[q], q, 1'b0);
        end
        s[0] ^= rka[r];
        s[1] ^= rkb[r];
        s[3] ^= LANE3_MARK ^ {8'h00, RC_TABLE[r]};
        if (((r + 1) % 4) == 0 && r < NUM_ROUNDS - 1) begin
          s[2] ^= tw2;
        end
      end
    end else begin
      for (int r = NUM_ROUNDS - 1; r >= 0; r--) begin
        s[3] ^= LANE3_MARK ^ {8'h00, RC_TABLE[r]};
        if (((r + 1) % 4) == 0 && r < NUM_ROUNDS - 1) begin
          s[2] ^= tw2;
        end
        s[0] ^= rka[r];
        s[1] ^= rkb[r];
        for (int q = 0; q < 4; q++) begin
          s[q] = lane_shuffle(s[q], q, 1'b1);
        end
        s = sbox_layer_inv(s);
      end
    end
    for (int i = 0; i < 64; i++) begin
      res[i] = s[i % 4][i / 4];
    end
    return res;
  endfunction

  function automatic logic [63:0] rand_block();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [7:0] rand_tweak();
    if ($urandom_range(0, 3) == 0) begin
      return 8'h00;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Offers one input beat after a random gap and records the block it should yield.
  task automatic send_block(input logic op, input logic [63:0] blk, input logic [7:0] tw);
    int          idle;
    logic [63:0] want;
    idle = steady ? 0 : $urandom_range(0, 3);
    want = gift_transform(op, blk, tw);
    @(negedge clk);
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    block_in   <= blk;
    tweak_byte <= tw;
    do @(posedge clk); while (!in_ready);
    pending_blocks.push_back(want);
  endtask

  // Stops offering beats, waits for every owed result, then lets the pipeline empty.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (LATENCY_PAD) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    case (idx)
      REG_KEY_LOW:  key_low_model = data;
      REG_KEY_HIGH: key_high_model = data;
      default: ;
    endcase
  endtask

  // The key must read as zero straight after reset.
  task automatic test_reset_key();
    send_block(OP_ENCRYPT, 64'h0, 8'h00);
    send_block(OP_DECRYPT, 64'h0, 8'h00);
    send_block(OP_ENCRYPT, '1, 8'hFF);
    settle();
  endtask

  // Writes to indexes beyond the key registers must leave the key alone.
  task automatic test_spare_index();
    write_reg(REG_SPARE_2, {$urandom, $urandom});
    write_reg(REG_SPARE_3, '1);
    send_block(OP_ENCRYPT, 64'h0123_4567_89AB_CDEF, 8'h5A);
    send_block(OP_DECRYPT, '1, 8'h00);
    settle();
  endtask

  // Extreme blocks and tweaks in both directions under extreme keys.
  task automatic test_extremes();
    logic [63:0] patterns [4];
    logic [7:0]  tweaks [4];
    patterns = '{64'h0, '1, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA};
    tweaks   = '{8'h00, 8'hFF, 8'h01, 8'h80};
    write_reg(REG_KEY_LOW, '1);
    write_reg(REG_KEY_HIGH, '1);
    for (int i = 0; i < 4; i++) begin
      send_block(OP_ENCRYPT, patterns[i], tweaks[i]);
      send_block(OP_DECRYPT, patterns[i], tweaks[3 - i]);
    end
    settle();
    write_reg(REG_KEY_LOW, 64'hFEDC_BA98_7654_3210);
    write_reg(REG_KEY_HIGH, 64'h0);
    for (int i = 0; i < 4; i++) begin
      send_block(i % 2 ? OP_DECRYPT : OP_ENCRYPT, patterns[i], tweaks[i]);
    end
    settle();
  endtask

  // Random blocks under one key; some results are fed straight back the other way.
  task automatic test_random(input logic [63:0] low_half, input logic [63:0] high_half,
                             input int count);
    int          n;
    logic        op;
    logic [63:0] blk;
    logic [7:0]  tw;
    write_reg(REG_KEY_LOW, low_half);
    write_reg(REG_KEY_HIGH, high_half);
    n = 0;
    while (n < count) begin
      steady = (n % 128) < 24;
      op  = $urandom_range(0, 1) ? OP_DECRYPT : OP_ENCRYPT;
      blk = rand_block();
      tw  = rand_tweak();
      send_block(op, blk, tw);
      n++;
      if ($urandom_range(0, 3) == 0) begin
        send_block(op == OP_ENCRYPT ? OP_DECRYPT : OP_ENCRYPT, gift_transform(op, blk, tw), tw);
        n++;
      end
    end
    steady = 1'b0;
    settle();
  endtask

  // Output side: random stall before each result beat, none in steady stretches.
  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      stall = steady ? 0 : $urandom_range(0, 3);
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compare each result beat with the oldest owed block.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_blocks.size() == 0) begin
        if (mismatch_count < MAX_REPORTS) begin
          $display("unexpected result beat: block_out %h", block_out);
        end
        mismatch_count++;
      end else begin
        owed_block = pending_blocks.pop_front();
        if (block_out !== owed_block) begin
          if (mismatch_count < MAX_REPORTS) begin
            $display("block_out mismatch: expected %h, got %h", owed_block, block_out);
          end
          mismatch_count++;
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst            = 1'b1;
    cfg_write_en   = 1'b0;
    cfg_index      = REG_KEY_LOW;
    cfg_data       = '0;
    in_valid       = 1'b0;
    opcode         = OP_ENCRYPT;
    block_in       = '0;
    tweak_byte     = '0;
    key_low_model  = '0;
    key_high_model = '0;
    steady         = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_key();
    test_spare_index();
    test_extremes();
    test_random({$urandom, $urandom}, {$urandom, $urandom}, 250);
    test_random(64'h0, 64'h0, 250);
    test_random('1, '1, 250);
    test_random('1, 64'h0, 250);
    test_random(64'h0, '1, 250);
    test_random({$urandom, $urandom}, {$urandom, $urandom}, 250);
    test_random({$urandom, $urandom}, {$urandom, $urandom}, 250);

    if (mismatch_count == 0 && pending_blocks.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
